// File: rtl/tli_pkg.sv
package tli_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int WAVE_W         = 16;
   localparam int TRANS_W        = 17;
   localparam int NUM_W          = 32;
   localparam int DIV_STEPS      = 17;
   localparam int BUILTIN_COUNT  = 11;
   localparam int REQ_TDATA_W    = 40;
   localparam int REQ_TUSER_W    = 2;
   localparam int RSP_TDATA_W    = 24;

   localparam logic [TRANS_W-1:0] ONE_Q16 = 17'd65536;

   typedef struct packed {
      logic [WAVE_W-1:0]  wave;
      logic [TRANS_W-1:0] trans;
   } point_type;

   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_LAST = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      RES_ONE  = 3'd0,
      RES_READ = 3'd1,
      RES_LAST = 3'd2,
      RES_LEFT = 3'd3,
      RES_LERP = 3'd4
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        query_start;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        prev_load;
      logic        last_load;
      logic        idx_inc;
      logic        mul_load;
      logic        div_start;
      logic        res_load;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic w_le_rd;
      logic w_ge_rd;
      logic hit;
      logic zero_width;
      logic idx_last;
      logic div_done;
      logic out_free;
   } stat_type;

   // Power-up breakpoints: 160 to 600 nm in Q10.6 with Q1.16 transmission.
   function automatic point_type builtin_point(input int unsigned idx);
      point_type p;
      p = '0;
      case (idx)
         0: begin
            p.wave = 16'd10240; p.trans = 17'd7;
         end
         1: begin
            p.wave = 16'd10880; p.trans = 17'd66;
         end
         2: begin
            p.wave = 16'd11200; p.trans = 17'd655;
         end
         3: begin
            p.wave = 16'd11392; p.trans = 17'd29491;
         end
         4: begin
            p.wave = 16'd12160; p.trans = 17'd57672;
         end
         5: begin
            p.wave = 16'd12800; p.trans = 17'd58327;
         end
         6: begin
            p.wave = 16'd16000; p.trans = 17'd58982;
         end
         7: begin
            p.wave = 16'd19200; p.trans = 17'd59638;
         end
         8: begin
            p.wave = 16'd25600; p.trans = 17'd60948;
         end
         9: begin
            p.wave = 16'd32000; p.trans = 17'd61604;
         end
         10: begin
            p.wave = 16'd38400; p.trans = 17'd62259;
         end
         default: begin
            p = '0;
         end
      endcase
      return p;
   endfunction

endpackage

// File: rtl/tli_div.sv
module tli_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tli_pkg::NUM_W-1:0]  num,
   input  logic [tli_pkg::WAVE_W-1:0] den,
   output logic                       done,
   output logic [tli_pkg::TRANS_W-1:0] quot
);
   import tli_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [WAVE_W-1:0]  rem_ff, rem_in;
   logic [TRANS_W-1:0] quo_ff;
   logic [WAVE_W-1:0]  den_ff;
   logic [WAVE_W:0]    trial;
   logic [WAVE_W:0]    diff;
   logic               ge;

   // Restoring division, one quotient bit per cycle. The caller guarantees
   // that the upper dividend bits are below the divisor.
   always_comb begin
      trial  = {rem_ff, quo_ff[TRANS_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = (trial >= {1'b0, den_ff});
      rem_in = ge ? diff[WAVE_W-1:0] : trial[WAVE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= WAVE_W'(num[NUM_W-1:TRANS_W]);
         quo_ff <= num[TRANS_W-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[TRANS_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// File: rtl/tli_dp.sv
module tli_dp #(
   parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tli_pkg::cmd_type            cmd,
   input  logic [tli_pkg::WAVE_W-1:0]  wavelength,
   input  logic [tli_pkg::TRANS_W-1:0] point_transmission,
   input  logic                        first_point,
   input  logic                        rsp_tready,
   output tli_pkg::stat_type           stat,
   output logic                        rsp_valid,
   output logic [tli_pkg::TRANS_W-1:0] rsp_transmission
);
   import tli_pkg::*;

   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int RESET_COUNT = (BUILTIN_COUNT < MAX_POINTS) ? BUILTIN_COUNT : MAX_POINTS;

   point_type mem [MAX_POINTS];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   windex_ff, windex_in;
   logic               builtin_ff, builtin_in;
   logic               out_valid_ff, out_valid_in;
   logic [TRANS_W-1:0] out_data_ff;
   logic [WAVE_W-1:0]  w_ff;
   logic [IDX_W-1:0]   idx_ff;
   point_type          prev_ff;
   logic [TRANS_W-1:0] last_t_ff;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [TRANS_W-1:0] res_ff, res_in;
   point_type          mem_rd_ff;
   point_type          bi_rd_ff;
   logic               rd_bi_ff;

   logic [CNT_W-1:0]   widx;
   logic               load_ok;
   point_type          wr_point;
   logic [CNT_W-1:0]   cnt_m1;
   logic [IDX_W-1:0]   raddr;
   point_type          rd;
   logic               up;
   logic [WAVE_W-1:0]  dw;
   logic [WAVE_W-1:0]  den;
   logic [TRANS_W-1:0] mag;
   logic [WAVE_W+TRANS_W-1:0] prod;
   logic               div_done;
   logic [TRANS_W-1:0] quot;

   // Table loading. A restart writes at entry zero; a full table ignores
   // appends. Transmission is saturated at one.
   always_comb begin
      widx    = first_point ? '0 : windex_ff;
      load_ok = cmd.load && (first_point || (windex_ff < CNT_W'(MAX_POINTS)));
      wr_point.wave  = wavelength;
      wr_point.trans = (point_transmission > ONE_Q16) ? ONE_Q16 : point_transmission;
      count_in   = count_ff;
      windex_in  = windex_ff;
      builtin_in = builtin_ff;
      if (load_ok) begin
         windex_in  = widx + CNT_W'(1);
         count_in   = widx + CNT_W'(1);
         builtin_in = 1'b0;
      end
   end

   always_comb begin
      cnt_m1 = count_ff - CNT_W'(1);
      case (cmd.rd_sel)
         RD_ZERO: begin
            raddr = '0;
         end
         RD_LAST: begin
            raddr = cnt_m1[IDX_W-1:0];
         end
         RD_NEXT: begin
            raddr = idx_ff + IDX_W'(1);
         end
         default: begin
            raddr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         mem[widx[IDX_W-1:0]] <= wr_point;
      end
      if (cmd.rd_en) begin
         mem_rd_ff <= mem[raddr];
      end
   end

   // Until the first load, reads come from the power-up breakpoint list.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         bi_rd_ff <= builtin_point(32'(raddr));
         rd_bi_ff <= builtin_ff;
      end
   end

   assign rd = rd_bi_ff ? bi_rd_ff : mem_rd_ff;

   // Interpolation terms from the enclosing interval held in prev_ff and rd.
   always_comb begin
      up     = (rd.trans >= prev_ff.trans);
      dw     = w_ff - prev_ff.wave;
      den    = rd.wave - prev_ff.wave;
      mag    = up ? (rd.trans - prev_ff.trans) : (prev_ff.trans - rd.trans);
      prod   = {{TRANS_W{1'b0}}, dw} * {{WAVE_W{1'b0}}, mag};
      num_in = prod[NUM_W-1:0] + NUM_W'(den[WAVE_W-1:1]);
   end

   always_comb begin
      case (cmd.res_sel)
         RES_ONE: begin
            res_in = ONE_Q16;
         end
         RES_READ: begin
            res_in = rd.trans;
         end
         RES_LAST: begin
            res_in = last_t_ff;
         end
         RES_LEFT: begin
            res_in = prev_ff.trans;
         end
         RES_LERP: begin
            res_in = up ? (prev_ff.trans + quot) : (prev_ff.trans - quot);
         end
         default: begin
            res_in = ONE_Q16;
         end
      endcase
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_W'(RESET_COUNT);
         windex_ff    <= '0;
         builtin_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         windex_ff    <= windex_in;
         builtin_ff   <= builtin_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         w_ff   <= wavelength;
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.prev_load) begin
         prev_ff <= rd;
      end
      if (cmd.last_load) begin
         last_t_ff <= rd.trans;
      end
      if (cmd.mul_load) begin
         num_ff <= num_in;
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.out_load) begin
         out_data_ff <= res_ff;
      end
   end

   tli_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      stat.count_zero = (count_ff == '0);
      stat.w_le_rd    = (w_ff <= rd.wave);
      stat.w_ge_rd    = (w_ff >= rd.wave);
      stat.hit        = (w_ff >= prev_ff.wave) && (w_ff <= rd.wave);
      stat.zero_width = (rd.wave <= prev_ff.wave);
      stat.idx_last   = ({{(CNT_W-IDX_W){1'b0}}, idx_ff} == cnt_m1);
      stat.div_done   = div_done;
      stat.out_free   = !out_valid_ff || rsp_tready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_transmission = out_data_ff;

endmodule

// File: rtl/tli_ctrl.sv
module tli_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_func,
   input  tli_pkg::stat_type stat,
   output logic              req_tready,
   output tli_pkg::cmd_type  cmd
);
   import tli_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CHK_FIRST = 8'b0000_0010,
      ST_CHK_LAST  = 8'b0000_0100,
      ST_SCAN      = 8'b0000_1000,
      ST_MUL       = 8'b0001_0000,
      ST_DIV_START = 8'b0010_0000,
      ST_DIV_WAIT  = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd         = '0;
      cmd.rd_sel  = RD_ZERO;
      cmd.res_sel = RES_ONE;
      state_in    = state_ff;
      req_tready  = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_func) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.query_start = 1'b1;
                  if (stat.count_zero) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RES_ONE;
                     state_in     = ST_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     state_in   = ST_CHK_FIRST;
                  end
               end
            end
         end
         ST_CHK_FIRST: begin
            cmd.prev_load = 1'b1;
            if (stat.w_le_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_READ;
               state_in     = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            if (stat.w_ge_rd) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_READ;
               state_in     = ST_DONE;
            end else begin
               cmd.last_load = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_NEXT;
               cmd.idx_inc   = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = ST_MUL;
            end else if (stat.idx_last) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_LAST;
               state_in     = ST_DONE;
            end else begin
               cmd.prev_load = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RD_NEXT;
               cmd.idx_inc   = 1'b1;
            end
         end
         ST_MUL: begin
            if (stat.zero_width) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_LEFT;
               state_in     = ST_DONE;
            end else begin
               cmd.mul_load = 1'b1;
               state_in     = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_LERP;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/table_linear_interpolator.sv
// Piecewise linear lookup of transmission versus wavelength. The block keeps
// up to MAX_POINTS breakpoints (wavelength in unsigned Q10.6 nm, transmission
// in Q1.16) in ascending wavelength order; after reset it holds eleven
// built-in points from 160 to 600 nm. A load transaction (tuser bit 0 high)
// writes one point; tuser bit 1 restarts the table at entry zero, appends past
// MAX_POINTS are dropped, and transmissions above 1.0 are saturated. A query
// transaction (tuser bit 0 low) returns one result: the end value when the
// wavelength lies at or beyond either end of the table, 1.0 for an empty
// table, otherwise the linear interpolation within the first enclosing
// interval, rounded to nearest. The search walks the table one entry per
// cycle through a single memory read port, and the interpolation then runs a
// 17-step restoring divider that holds the controller until it finishes. A
// zero-width interval skips the division. A result that is not taken holds
// the next query's result in the controller until the output register frees.
// Queries are handled one at a time; the result sits in an output register,
// so the next transaction can be accepted while it waits to be taken. There
// is no clearing pass after reset.
module table_linear_interpolator #(
   parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] wavelength, [32:16] point_transmission, [39:33] zero.
   input  logic [tli_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] func, [1] first_point.
   input  logic [tli_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [16:0] transmission, [23:17] zero.
   output logic [tli_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import tli_pkg::*;

   cmd_type            cmd;
   stat_type           stat;
   logic [TRANS_W-1:0] rsp_transmission;

   // The controller sequences every query; the datapath owns the table,
   // the search registers, the multiplier and the divider.
   tli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser[0]),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   tli_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .wavelength         (req_tdata[WAVE_W-1:0]),
      .point_transmission (req_tdata[WAVE_W+TRANS_W-1:WAVE_W]),
      .first_point        (req_tuser[1]),
      .rsp_tready         (rsp_tready),
      .stat               (stat),
      .rsp_valid          (rsp_tvalid),
      .rsp_transmission   (rsp_transmission)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_transmission);

   // A query always moves the controller out of its idle state, so the input side must close
   // right after one is accepted.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0]) |=> !req_tready)
      else $error("input accepted again right after a query");

   // Every result is a transmission of at most 1.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[TRANS_W-1:0] <= ONE_Q16))
      else $error("result transmission above 1.0");

   // The divider never reports completion in the cycle after it was started.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !stat.div_done)
      else $error("divider finished too early");

endmodule

// File: bench/table_linear_interpolator_test.sv
`timescale 1ns / 1ps

module table_linear_interpolator_test;
   import tli_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int MAX_POINTS      = MAX_POINTS_DEF;
   localparam int ITEM_TARGET     = 900;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int SETTLE_CYCLES   = 120;
   localparam int HOLD_OFF_AT     = 150;
   localparam int HOLD_OFF_CYCLES = 400;

   // Operation codes carried in tuser bit 0.
   localparam logic FUNC_QUERY = 1'b0;
   localparam logic FUNC_LOAD  = 1'b1;

   // Power-up breakpoints of the block, ascending wavelength (Q10.6) and
   // transmission (Q1.16).
   localparam int BUILTIN_POINTS = 11;
   localparam logic [WAVE_W-1:0] BUILTIN_WAVE [0:BUILTIN_POINTS-1] = '{
      16'd10240, 16'd10880, 16'd11200, 16'd11392, 16'd12160, 16'd12800,
      16'd16000, 16'd19200, 16'd25600, 16'd32000, 16'd38400
   };
   localparam logic [TRANS_W-1:0] BUILTIN_TRANS [0:BUILTIN_POINTS-1] = '{
      17'd7, 17'd66, 17'd655, 17'd29491, 17'd57672, 17'd58327,
      17'd58982, 17'd59638, 17'd60948, 17'd61604, 17'd62259
   };

   // One request transaction plus the pacing the driver applies to it.
   typedef struct {
      logic               func;
      logic [WAVE_W-1:0]  wave;
      logic [TRANS_W-1:0] trans;
      logic               first;
      int unsigned        idle;
      bit                 drain;
   } request_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [15:0] wavelength, [32:16] point_transmission, [39:33] zero.
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] func, [1] first_point.
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [16:0] transmission, [23:17] zero.
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   table_linear_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Shadow copy of the breakpoint table, advanced as each transaction is
   // accepted by the block.
   logic [WAVE_W-1:0]  bp_wave  [0:MAX_POINTS-1];
   logic [TRANS_W-1:0] bp_trans [0:MAX_POINTS-1];
   int unsigned        bp_count;
   int unsigned        bp_next;

   // Stimulus waiting to be offered, and transmissions still owed by the block.
   request_item_type   pending_items[$];
   logic [TRANS_W-1:0] owed_transmission[$];

   // Wavelengths of the table as the stimulus plans it; only used to aim the
   // query wavelengths at interesting places.
   logic [WAVE_W-1:0]  plan_wave[$];
   bit                 idle_calm;
   bit                 next_drain;
   int unsigned        planned_items;

   request_item_type   offered;
   int unsigned        idle_left;
   int unsigned        items_sent;
   int unsigned        queries_sent;
   int unsigned        loads_dropped;
   int unsigned        clamp_hits;
   int unsigned        interp_hits;

   int unsigned        results_taken;
   int unsigned        hold_left;
   int unsigned        ready_gap;
   bit                 rsp_calm;
   logic [TRANS_W-1:0] want;
   int unsigned        error_count;
   int unsigned        cycle_count;

   // Linear interpolation inside interval k. A zero-width (or backwards)
   // interval gives its left value. The step magnitude is rounded to nearest
   // with halves going away from the left value.
   function automatic logic [TRANS_W-1:0] interpolate(input logic [WAVE_W-1:0] w,
                                                      input int unsigned k);
      longint unsigned den;
      longint unsigned mag;
      longint unsigned step;
      if (bp_wave[k+1] <= bp_wave[k])
         return bp_trans[k];
      den = bp_wave[k+1] - bp_wave[k];
      if (bp_trans[k+1] >= bp_trans[k])
         mag = bp_trans[k+1] - bp_trans[k];
      else
         mag = bp_trans[k] - bp_trans[k+1];
      step = (longint'(w - bp_wave[k]) * mag + den / 2) / den;
      if (bp_trans[k+1] >= bp_trans[k])
         return bp_trans[k] + TRANS_W'(step);
      return bp_trans[k] - TRANS_W'(step);
   endfunction

   // Transmission the block must return for a query at wavelength w.
   function automatic logic [TRANS_W-1:0] lookup_transmission(input logic [WAVE_W-1:0] w);
      int unsigned n;
      n = (bp_count > MAX_POINTS) ? MAX_POINTS : bp_count;
      if (n == 0)
         return ONE_Q16;
      if (w <= bp_wave[0] || w >= bp_wave[n-1]) begin
         clamp_hits++;
         return (w <= bp_wave[0]) ? bp_trans[0] : bp_trans[n-1];
      end
      for (int unsigned k = 0; k + 1 < n; k++) begin
         if (w >= bp_wave[k] && w <= bp_wave[k+1]) begin
            interp_hits++;
            return interpolate(w, k);
         end
      end
      // Only a table that is out of order can leave the wavelength unclaimed.
      return bp_trans[n-1];
   endfunction

   // A point load: restart on first, drop past a full table, saturate at 1.0.
   function automatic void store_point(input logic [WAVE_W-1:0] w,
                                       input logic [TRANS_W-1:0] t,
                                       input logic first);
      if (first)
         bp_next = 0;
      if (bp_next < MAX_POINTS) begin
         bp_wave[bp_next]  = w;
         bp_trans[bp_next] = (t > ONE_Q16) ? ONE_Q16 : t;
         bp_next++;
         bp_count = bp_next;
      end else begin
         loads_dropped++;
      end
   endfunction

   // Queue one transaction for the driver and keep the planned table current.
   function automatic void add_item(input logic func, input logic [WAVE_W-1:0] w,
                                    input logic [TRANS_W-1:0] t, input logic first);
      request_item_type item;
      item.func  = func;
      item.wave  = w;
      item.trans = t;
      item.first = first;
      item.idle  = idle_calm ? 0 : $urandom_range(0, 3);
      item.drain = next_drain;
      next_drain = 1'b0;
      pending_items.push_back(item);
      if (func == FUNC_LOAD) begin
         if (first)
            plan_wave.delete();
         if (plan_wave.size() < MAX_POINTS) begin
            plan_wave.push_back(w);
            planned_items++;
         end
      end else begin
         planned_items++;
      end
   endfunction

   // Transmission for a loaded point: mostly in range, sometimes right at the
   // ends, sometimes above 1.0 so that saturation is exercised.
   function automatic logic [TRANS_W-1:0] pick_transmission();
      case ($urandom_range(0, 7))
         0: return TRANS_W'($urandom_range(65537, 131071));
         1: return $urandom_range(0, 1) ? ONE_Q16 : '0;
         default: return TRANS_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // Query wavelength aimed mostly inside the planned table, with exact
   // breakpoints, near misses and the extremes mixed in.
   function automatic logic [WAVE_W-1:0] pick_wavelength();
      int unsigned lo;
      int unsigned hi;
      int unsigned bp;
      lo = plan_wave[0];
      hi = plan_wave[plan_wave.size()-1];
      bp = plan_wave[$urandom_range(0, plan_wave.size() - 1)];
      case ($urandom_range(0, 9))
         0: return WAVE_W'($urandom_range(0, 65535));
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         2: return WAVE_W'(bp);
         3: begin
            if ($urandom_range(0, 1) && bp < 65535)
               return WAVE_W'(bp + 1);
            return (bp > 0) ? WAVE_W'(bp - 1) : WAVE_W'(bp);
         end
         default: return WAVE_W'($urandom_range(lo, hi));
      endcase
   endfunction

   // Driver: offers one queued transaction at a time, waits the idle count
   // drawn for it, and holds back an item marked for draining until every
   // owed result has been taken. The prediction is made at the edge where
   // the block accepts the transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         idle_left = 0;
         for (int unsigned k = 0; k < MAX_POINTS; k++) begin
            bp_wave[k]  = '0;
            bp_trans[k] = '0;
            if (k < BUILTIN_POINTS) begin
               bp_wave[k]  = BUILTIN_WAVE[k];
               bp_trans[k] = BUILTIN_TRANS[k];
            end
         end
         bp_count = BUILTIN_POINTS;
         bp_next  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (offered.func == FUNC_LOAD) begin
               store_point(offered.wave, offered.trans, offered.first);
            end else begin
               owed_transmission.push_back(lookup_transmission(offered.wave));
               queries_sent++;
            end
            items_sent++;
            if (pending_items.size() != 0)
               idle_left = pending_items[0].idle;
         end
         // A transaction that has not been taken yet stays on the bus as it is.
         if (!(req_tvalid && !req_tready)) begin
            if (idle_left != 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && queries_sent != results_taken)) begin
               offered = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, offered.trans, offered.wave};
               req_tuser  <= {offered.first, offered.func};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes each result transaction, compares it with the oldest
   // owed transmission, then drops tready for a drawn number of cycles. Once,
   // after a fixed count of results, it holds tready low for a long stretch
   // so that the block backs up into its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         results_taken <= 0;
         hold_left = 0;
         ready_gap = 0;
         rsp_calm  = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_transmission.size() == 0) begin
               $display("%0t: result with none owed, expected nothing, got %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = owed_transmission.pop_front();
               if (rsp_tdata !== {7'd0, want}) begin
                  $display("%0t: transmission expected %h, got %h",
                           $time, {7'd0, want}, rsp_tdata);
                  error_count++;
               end
            end
            results_taken <= results_taken + 1;
            if (results_taken + 1 == HOLD_OFF_AT)
               hold_left = HOLD_OFF_CYCLES;
            if ((results_taken + 1) % 50 == 0)
               rsp_calm = ($urandom_range(0, 2) == 0);
            ready_gap = rsp_calm ? 0 : $urandom_range(0, 3);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (ready_gap != 0) begin
            ready_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("table_linear_interpolator: mismatch");
         $finish;
      end
   end

   initial begin
      int unsigned n;
      int unsigned base;
      int unsigned max_step;
      int unsigned w;
      int unsigned phase_kind;

      cycle_count   = 0;
      error_count   = 0;
      items_sent    = 0;
      queries_sent  = 0;
      loads_dropped = 0;
      clamp_hits    = 0;
      interp_hits   = 0;
      planned_items = 0;
      idle_calm     = 1'b0;
      next_drain    = 1'b0;
      for (int k = 0; k < BUILTIN_POINTS; k++)
         plan_wave.push_back(BUILTIN_WAVE[k]);

      // Directed part on the power-up table: below and at the first point,
      // inside steep and flat intervals, exactly on a breakpoint, at and past
      // the last point, and the wavelength extremes.
      add_item(FUNC_QUERY, 16'd0,     '0, 1'b0);
      add_item(FUNC_QUERY, 16'd10240, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd10560, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd11300, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd11392, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd20000, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd38400, '0, 1'b0);
      add_item(FUNC_QUERY, 16'hFFFF,  '0, 1'b1);

      // A load without restart right after reset starts a new one-point
      // table; its transmission is far above 1.0 and must saturate. The
      // sender first waits for every owed result.
      next_drain = 1'b1;
      add_item(FUNC_LOAD,  16'd30000, 17'h1FFFF, 1'b0);
      add_item(FUNC_QUERY, 16'd0,     '0, 1'b0);
      add_item(FUNC_QUERY, 16'd30000, '0, 1'b0);
      add_item(FUNC_QUERY, 16'hFFFF,  '0, 1'b0);

      // A restarted table with repeated wavelengths (zero-width intervals)
      // and a falling interval.
      add_item(FUNC_LOAD, 16'd1000, ONE_Q16,   1'b1);
      add_item(FUNC_LOAD, 16'd1000, 17'd0,     1'b0);
      add_item(FUNC_LOAD, 16'd2000, 17'd100,   1'b0);
      add_item(FUNC_LOAD, 16'd2000, 17'd5000,  1'b0);
      add_item(FUNC_LOAD, 16'd4000, 17'd0,     1'b0);
      add_item(FUNC_QUERY, 16'd1000, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd1500, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd2000, '0, 1'b1);
      add_item(FUNC_QUERY, 16'd3000, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd3999, '0, 1'b0);
      add_item(FUNC_QUERY, 16'd4000, '0, 1'b0);

      // Random phases. Half reload an ascending table with random content;
      // some load out-of-order noise, some append to the current table, and
      // the rest keep it. Now and then the table is filled completely and
      // extra loads run past its end.
      while (planned_items < ITEM_TARGET) begin
         idle_calm  = ($urandom_range(0, 3) == 0);
         next_drain = ($urandom_range(0, 7) == 0);
         phase_kind = $urandom_range(0, 9);
         if (phase_kind < 5) begin
            n = ($urandom_range(0, 9) == 0) ? MAX_POINTS : $urandom_range(2, 12);
            base = $urandom_range(0, 12000);
            max_step = (65535 - base) / n;
            if (max_step > 4000)
               max_step = 4000;
            w = base;
            for (int k = 0; k < n; k++) begin
               add_item(FUNC_LOAD, WAVE_W'(w), pick_transmission(), k == 0);
               if ($urandom_range(0, 7) != 0)
                  w += $urandom_range(1, max_step);
            end
            if (n == MAX_POINTS) begin
               repeat ($urandom_range(1, 3))
                  add_item(FUNC_LOAD, WAVE_W'($urandom_range(0, 65535)),
                           pick_transmission(), 1'b0);
            end
         end else if (phase_kind < 7) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
               add_item(FUNC_LOAD, WAVE_W'($urandom_range(0, 65535)),
                        pick_transmission(),
                        (k == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
         end else if (phase_kind == 7) begin
            w = plan_wave[plan_wave.size()-1];
            repeat ($urandom_range(1, 4)) begin
               if (w < 60000)
                  w += $urandom_range(0, 1500);
               add_item(FUNC_LOAD, WAVE_W'(w), pick_transmission(), 1'b0);
            end
         end
         repeat ($urandom_range(10, 30))
            add_item(FUNC_QUERY, pick_wavelength(), pick_transmission(),
                     1'($urandom_range(0, 1)));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait until every transaction has gone in and every result has come
      // back, then give the block time to show any stray result.
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || owed_transmission.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d transactions: %0d queries (%0d clamped, %0d interpolated),",
               items_sent, queries_sent, clamp_hits, interp_hits);
      $display("%0d point loads with %0d dropped past a full table.",
               items_sent - queries_sent, loads_dropped);
      if (error_count == 0) begin
         $display("table_linear_interpolator: match");
      end else begin
         $display("table_linear_interpolator: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/tli_pkg.sv
rtl/tli_div.sv
rtl/tli_dp.sv
rtl/tli_ctrl.sv
rtl/table_linear_interpolator.sv
bench/table_linear_interpolator_test.sv
